// ===== design/dss_pkg.sv =====
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants for the dual stepper step generator.
// ----------------------------------------------------------------------------
`default_nettype none

package dss_pkg;

    localparam int NUM_CHANNELS_DEF = 2;
    localparam int DATA_W           = 16;
    localparam int WIDE_W           = 2 * DATA_W;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    localparam logic [3:0] OFF_POS_HI   = 4'd0;
    localparam logic [3:0] OFF_POS_LO   = 4'd1;
    localparam logic [3:0] OFF_CNT_HI   = 4'd2;
    localparam logic [3:0] OFF_CNT_LO   = 4'd3;
    localparam logic [3:0] OFF_DIR      = 4'd5;
    localparam logic [3:0] OFF_PERIOD   = 4'd6;
    localparam logic [3:0] OFF_CMD      = 4'd8;
    localparam logic [3:0] OFF_HOME     = 4'd9;
    localparam logic [3:0] OFF_RUNNING  = 4'd10;

    localparam logic [DATA_W-1:0] CMD_STOP      = 16'd0;
    localparam logic [DATA_W-1:0] CMD_START     = 16'd1;
    localparam logic [DATA_W-1:0] CMD_START_ALT = 16'd2;

    typedef struct packed {
        logic [1:0]               action;
        logic                     channel;
        logic [3:0]               reg_offset;
        logic signed [DATA_W-1:0] write_data;
        logic                     home_pin_0;
        logic                     home_pin_1;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_data;
        logic                     step_level_0;
        logic                     step_level_1;
        logic                     dir_level_0;
        logic                     dir_level_1;
    } t_out_item;

    // per-lane command for one transfer
    typedef struct packed {
        logic              tick;
        logic              home_active;
        logic              wr_en;
        logic [3:0]        offset;
        logic [DATA_W-1:0] wdata;
        logic [WIDE_W-1:0] latch;
    } t_lane_cmd;

    // per-lane state as seen by the merge stage
    typedef struct packed {
        logic [WIDE_W-1:0] position;
        logic [WIDE_W-1:0] steps_left;
        logic [DATA_W-1:0] period;
        logic              run;
        logic              dir;
        logic              n_step;
        logic              n_dir;
    } t_lane_stat;

endpackage

`default_nettype wire

// ===== design/dual_stepper_step_generator.sv =====
// ----------------------------------------------------------------------------
// dual_stepper_step_generator
// Stepper step pulse generator with a 16-bit register bus, one lane per channel.
// ----------------------------------------------------------------------------
// Takes one transfer (tick, register read or register write) every clock
// cycle unless intake stalls; its result appears from the output register
// in the next cycle. All channel lanes update in parallel in the cycle of
// the transfer, so the figure is set by the single lane update stage, and a
// full output register stalls intake only until the waiting result is taken.
`default_nettype none

module dual_stepper_step_generator #(
    parameter int NUM_CHANNELS = dss_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire dss_pkg::t_in_item  i_item,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output dss_pkg::t_out_item      o_item
);

    logic                        accept;
    logic [dss_pkg::WIDE_W-1:0]  latch;
    dss_pkg::t_lane_cmd          cmd  [NUM_CHANNELS];
    dss_pkg::t_lane_stat         stat [NUM_CHANNELS];

    assign accept = i_valid && o_ready;

    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
        always_comb begin
            cmd[g].tick   = accept && (i_item.action == dss_pkg::ACT_TICK);
            cmd[g].wr_en  = accept && (i_item.action == dss_pkg::ACT_WRITE) &&
                            (g == int'(i_item.channel));
            cmd[g].offset = i_item.reg_offset;
            cmd[g].wdata  = i_item.write_data;
            cmd[g].latch  = latch;
            if (g == 0) begin
                cmd[g].home_active = !i_item.home_pin_0;
            end else if (g == 1) begin
                cmd[g].home_active = !i_item.home_pin_1;
            end else begin
                cmd[g].home_active = 1'b0;
            end
        end

        dss_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd[g]),
            .o_stat  (stat[g])
        );
    end

    dss_merge #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_stat      (stat),
        .i_out_ready (i_ready),
        .o_in_ready  (o_ready),
        .o_latch     (latch),
        .o_valid     (o_valid),
        .o_item      (o_item)
    );

endmodule

`default_nettype wire

// ===== design/dss_lane.sv =====
// ----------------------------------------------------------------------------
// dss_lane
// One stepper channel: period countdown, step count, position, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_lane (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire dss_pkg::t_lane_cmd  i_cmd,
    output dss_pkg::t_lane_stat      o_stat
);

    logic [dss_pkg::WIDE_W-1:0] r_pos, n_pos;
    logic [dss_pkg::WIDE_W-1:0] r_steps, n_steps;
    logic [dss_pkg::DATA_W-1:0] r_period, n_period;
    logic [dss_pkg::DATA_W-1:0] r_cd, n_cd;
    logic                       r_run, n_run;
    logic                       r_dir, n_dir;
    logic                       r_pin, n_pin;

    logic                       stop;
    logic [dss_pkg::DATA_W-1:0] cd_dec;

    always_comb begin
        n_pos    = r_pos;
        n_steps  = r_steps;
        n_period = r_period;
        n_cd     = r_cd;
        n_run    = r_run;
        n_dir    = r_dir;
        n_pin    = r_pin;
        stop     = (i_cmd.home_active && r_dir) || (r_steps == '0);
        cd_dec   = (r_cd != '0) ? (r_cd - 16'd1) : r_cd;

        if (i_cmd.tick) begin
            if (!r_run || stop) begin
                n_run = 1'b0;
                n_pin = 1'b0;
            end else if (cd_dec == '0) begin
                n_cd    = r_period;
                n_steps = r_steps - 32'd1;
                n_pos   = r_dir ? (r_pos - 32'd1) : (r_pos + 32'd1);
                n_pin   = 1'b1;
            end else begin
                n_cd  = cd_dec;
                n_pin = 1'b0;
            end
        end

        if (i_cmd.wr_en) begin
            case (i_cmd.offset)
                dss_pkg::OFF_POS_LO: begin
                    n_pos = i_cmd.latch | {16'd0, i_cmd.wdata};
                end
                dss_pkg::OFF_CNT_LO: begin
                    n_steps = i_cmd.latch | {16'd0, i_cmd.wdata};
                end
                dss_pkg::OFF_DIR: begin
                    n_dir = (i_cmd.wdata != '0);
                end
                dss_pkg::OFF_PERIOD: begin
                    n_period = i_cmd.wdata;
                end
                dss_pkg::OFF_CMD: begin
                    if (i_cmd.wdata == dss_pkg::CMD_STOP) begin
                        n_run = 1'b0;
                    end else if (i_cmd.wdata == dss_pkg::CMD_START ||
                                 i_cmd.wdata == dss_pkg::CMD_START_ALT) begin
                        n_cd  = '0;
                        n_run = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_steps  <= '0;
            r_period <= '0;
            r_cd     <= '0;
            r_run    <= 1'b0;
            r_dir    <= 1'b0;
            r_pin    <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_steps  <= n_steps;
            r_period <= n_period;
            r_cd     <= n_cd;
            r_run    <= n_run;
            r_dir    <= n_dir;
            r_pin    <= n_pin;
        end
    end

    always_comb begin
        o_stat.position   = r_pos;
        o_stat.steps_left = r_steps;
        o_stat.period     = r_period;
        o_stat.run        = r_run;
        o_stat.dir        = r_dir;
        o_stat.n_step     = n_pin;
        o_stat.n_dir      = n_dir;
    end

endmodule

`default_nettype wire

// ===== design/dss_merge.sv =====
// ----------------------------------------------------------------------------
// dss_merge
// Register read mux, shared word latch and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_merge #(
    parameter int NUM_CHANNELS = dss_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire dss_pkg::t_in_item    i_item,
    input  wire dss_pkg::t_lane_stat  i_stat [NUM_CHANNELS],
    input  wire logic                 i_out_ready,
    output logic                      o_in_ready,
    output logic [dss_pkg::WIDE_W-1:0] o_latch,
    output logic                      o_valid,
    output dss_pkg::t_out_item        o_item
);

    logic [dss_pkg::WIDE_W-1:0] r_latch, n_latch;
    logic                       r_valid;
    dss_pkg::t_out_item         r_item, n_item;

    dss_pkg::t_lane_stat        sel;
    logic                       sel_ok;
    logic                       home_lvl;
    logic [dss_pkg::DATA_W-1:0] rd;

    always_comb begin
        sel    = i_stat[0];
        sel_ok = 1'b0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (c == int'(i_item.channel)) begin
                sel    = i_stat[c];
                sel_ok = 1'b1;
            end
        end
        home_lvl = i_item.channel ? i_item.home_pin_1 : i_item.home_pin_0;
    end

    always_comb begin
        rd      = '0;
        n_latch = r_latch;
        if (i_item.action == dss_pkg::ACT_READ && sel_ok) begin
            case (i_item.reg_offset)
                dss_pkg::OFF_POS_HI: begin
                    n_latch = sel.position;
                    rd      = sel.position[31:16];
                end
                dss_pkg::OFF_CNT_HI: begin
                    n_latch = sel.steps_left;
                    rd      = sel.steps_left[31:16];
                end
                dss_pkg::OFF_POS_LO,
                dss_pkg::OFF_CNT_LO: rd = r_latch[15:0];
                dss_pkg::OFF_DIR:     rd = {15'd0, sel.dir};
                dss_pkg::OFF_PERIOD:  rd = sel.period;
                dss_pkg::OFF_HOME:    rd = {15'd0, home_lvl};
                dss_pkg::OFF_RUNNING: rd = {15'd0, sel.run};
                default:              rd = '0;
            endcase
        end else if (i_item.action == dss_pkg::ACT_WRITE && sel_ok) begin
            if (i_item.reg_offset == dss_pkg::OFF_POS_HI ||
                i_item.reg_offset == dss_pkg::OFF_CNT_HI) begin
                n_latch = {i_item.write_data, 16'd0};
            end
        end
    end

    always_comb begin
        n_item              = '0;
        n_item.read_data    = rd;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (c == 0) begin
                n_item.step_level_0 = i_stat[c].n_step;
                n_item.dir_level_0  = i_stat[c].n_dir;
            end else if (c == 1) begin
                n_item.step_level_1 = i_stat[c].n_step;
                n_item.dir_level_1  = i_stat[c].n_dir;
            end
        end
    end

    assign o_in_ready = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_latch <= n_latch;
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item <= n_item;
        end
    end

    assign o_latch = r_latch;
    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== design/dss_checker.sv =====
// ----------------------------------------------------------------------------
// dss_checker
// Port-level checks for the dual stepper step generator.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_ready,
    input wire dss_pkg::t_in_item  i_item,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire dss_pkg::t_out_item o_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("result dropped or changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("intake stalled with empty output register");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> o_valid)
        else $error("transfer without a result");

    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_item.action != dss_pkg::ACT_READ
        |=> o_item.read_data == '0)
        else $error("nonzero read data for a tick or write");

endmodule

bind dual_stepper_step_generator dss_checker u_dss_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_item  (i_item),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_item  (o_item)
);

`default_nettype wire
